[rtl/char_lcd_nibble_sequencer_core_macros.svh]
// assertion helpers for the block that checks its own logic
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_CORE_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_CORE_MACROS_SVH

// condition implies consequence in the same cycle
`define CLNS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define CLNS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/clns_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package clns_pkg;

    // request codes
    localparam logic [2:0] OP_INIT  = 3'd0;
    localparam logic [2:0] OP_CMD   = 3'd1;
    localparam logic [2:0] OP_DATA  = 3'd2;
    localparam logic [2:0] OP_GOTO  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;
    localparam logic [2:0] OP_TIME  = 3'd5;

    // delays in units of 1000 loops
    localparam logic [7:0] WAIT_WAKE     = 8'd150;
    localparam logic [7:0] WAIT_FIRST    = 8'd50;
    localparam logic [7:0] WAIT_CMD      = 8'd52;
    localparam logic [7:0] WAIT_CHAR     = 8'd2;
    localparam logic [7:0] WAIT_NONE     = 8'd0;
    localparam logic [5:0] AFTER_INIT    = 6'd54;
    localparam logic [5:0] AFTER_SETTLE  = 6'd2;
    localparam logic [5:0] AFTER_CLEAR   = 6'd4;
    localparam logic [5:0] AFTER_NONE    = 6'd0;

    // display command and character bytes
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [3:0] NIB_WAKE      = 4'h3;
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;
    localparam logic [7:0] ASCII_COLON   = 8'h3A;
    localparam logic       GOTO_FLAG     = 1'b1;

    // time digit conversion
    localparam logic [6:0] DIGIT_BASE    = 7'd10;
    localparam logic [6:0] TIME_MAX      = 7'd99;

    // register select levels
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
        logic [7:0] wait_before;
        logic [5:0] wait_after;
        logic       last;
    } clns_strobe_t;

    typedef struct packed {
        logic       start;
        logic [6:0] value;
    } clns_div_req_t;

    typedef struct packed {
        logic       done;
        logic [3:0] tens;
        logic [3:0] ones;
    } clns_div_rsp_t;

    // power-up sequence: three wake strobes, then 02 28 0C 06 01
    function automatic clns_strobe_t clns_init_strobe(input logic [3:0] step);
        clns_strobe_t s;
        s = '{reg_select: RS_CMD, nibble: 4'h0, wait_before: WAIT_NONE,
              wait_after: AFTER_NONE, last: 1'b0};
        case (step)
            4'd0, 4'd1, 4'd2:
            begin
                s.nibble      = NIB_WAKE;
                s.wait_before = WAIT_WAKE;
            end
            4'd3:
            begin
                s.nibble      = 4'h0;
                s.wait_before = WAIT_FIRST;
            end
            4'd4:  s.nibble = 4'h2;
            4'd5:
            begin
                s.nibble      = 4'h2;
                s.wait_before = WAIT_CMD;
            end
            4'd6:  s.nibble = 4'h8;
            4'd7:
            begin
                s.nibble      = 4'h0;
                s.wait_before = WAIT_CMD;
            end
            4'd8:  s.nibble = 4'hC;
            4'd9:
            begin
                s.nibble      = 4'h0;
                s.wait_before = WAIT_CMD;
            end
            4'd10: s.nibble = 4'h6;
            4'd11:
            begin
                s.nibble      = 4'h0;
                s.wait_before = WAIT_CMD;
            end
            4'd12:
            begin
                s.nibble     = 4'h1;
                s.wait_after = AFTER_INIT;
                s.last       = 1'b1;
            end
            default: s.nibble = 4'h0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[rtl/clns_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// request channel
interface clns_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] byte_value;
    logic       row;
    logic [5:0] col;
    logic [6:0] hours;
    logic [6:0] minutes;
    logic [6:0] seconds;

    modport source (output valid, op, byte_value, row, col, hours, minutes, seconds,
                    input ready);
    modport sink   (input valid, op, byte_value, row, col, hours, minutes, seconds,
                    output ready);
endinterface

// strobe channel
interface clns_strobe_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic [3:0] nibble;
    logic [7:0] wait_before;
    logic [5:0] wait_after;
    logic       last;

    modport source (output valid, reg_select, nibble, wait_before, wait_after, last,
                    input ready);
    modport sink   (input valid, reg_select, nibble, wait_before, wait_after, last,
                    output ready);
endinterface

`default_nettype wire

[rtl/clns_div10.sv]
`timescale 1ns / 1ps
`default_nettype none

// shared subtract-and-compare unit: splits a time value into two decimal digits
module clns_div10
    import clns_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire clns_div_req_t dreq,
    output clns_div_rsp_t      drsp
);

    logic       busy_reg, busy_next;
    logic [6:0] rem_reg, rem_next;
    logic [3:0] tens_reg, tens_next;
    logic       rem_small;

    assign rem_small = (rem_reg < DIGIT_BASE);

    // finished once the remainder is below ten
    always_comb
    begin
        drsp.done = busy_reg && rem_small;
        drsp.tens = tens_reg;
        drsp.ones = rem_reg[3:0];
    end

    // load with saturation, then one subtraction of ten a cycle
    always_comb
    begin
        busy_next = busy_reg;
        rem_next  = rem_reg;
        tens_next = tens_reg;
        if (dreq.start)
        begin
            busy_next = 1'b1;
            rem_next  = (dreq.value > TIME_MAX) ? TIME_MAX : dreq.value;
            tens_next = 4'd0;
        end
        else if (busy_reg)
        begin
            if (rem_small)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                rem_next  = rem_reg - DIGIT_BASE;
                tens_next = tens_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        tens_reg <= tens_next;
    end

endmodule

`default_nettype wire

[rtl/clns_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

// request sequencer: takes a request, runs the digit unit, steps through the strobes
module clns_seq
    import clns_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    clns_req_if.sink           req,
    output clns_div_req_t      dreq,
    input  wire clns_div_rsp_t drsp,
    output logic               gen_valid,
    input  wire logic          gen_ready,
    output clns_strobe_t       gen_item
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] fld_reg, fld_next;

    logic [2:0] op_reg;
    logic [7:0] byte_reg;
    logic       row_reg;
    logic [5:0] col_reg;
    logic [6:0] min_reg;
    logic [6:0] sec_reg;
    logic [3:0] tens_reg [3];
    logic [3:0] ones_reg [3];

    logic       accept;
    logic [7:0] byte_sel;
    logic [7:0] char_sel;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign gen_valid = (state_reg == ST_EMIT);

    // byte for the two-strobe requests
    always_comb
    begin
        case (op_reg)
            OP_GOTO:  byte_sel = {GOTO_FLAG, row_reg, col_reg};
            OP_CLEAR: byte_sel = CMD_CLEAR;
            default:  byte_sel = byte_reg;
        endcase
    end

    // character of the time string, two strobes each
    always_comb
    begin
        case (step_reg[3:1])
            3'd0:    char_sel = {ASCII_DIGIT_HI, tens_reg[0]};
            3'd1:    char_sel = {ASCII_DIGIT_HI, ones_reg[0]};
            3'd3:    char_sel = {ASCII_DIGIT_HI, tens_reg[1]};
            3'd4:    char_sel = {ASCII_DIGIT_HI, ones_reg[1]};
            3'd6:    char_sel = {ASCII_DIGIT_HI, tens_reg[2]};
            3'd7:    char_sel = {ASCII_DIGIT_HI, ones_reg[2]};
            default: char_sel = ASCII_COLON;
        endcase
    end

    // strobe for the current step
    always_comb
    begin
        gen_item = '{reg_select: RS_CMD, nibble: 4'h0, wait_before: WAIT_NONE,
                     wait_after: AFTER_NONE, last: 1'b0};
        if (op_reg == OP_INIT)
        begin
            gen_item = clns_init_strobe(step_reg);
        end
        else if (op_reg == OP_TIME)
        begin
            gen_item.reg_select  = RS_DATA;
            gen_item.nibble      = step_reg[0] ? char_sel[3:0] : char_sel[7:4];
            gen_item.wait_before = (!step_reg[0] && (step_reg != 4'd0)) ? WAIT_CHAR
                                                                         : WAIT_NONE;
            gen_item.last        = (step_reg == 4'd15);
            gen_item.wait_after  = gen_item.last ? AFTER_SETTLE : AFTER_NONE;
        end
        else if (op_reg inside {OP_CMD, OP_DATA, OP_GOTO, OP_CLEAR})
        begin
            gen_item.reg_select = (op_reg == OP_DATA) ? RS_DATA : RS_CMD;
            gen_item.nibble     = step_reg[0] ? byte_sel[3:0] : byte_sel[7:4];
            gen_item.last       = step_reg[0];
            if (step_reg[0])
            begin
                gen_item.wait_after = (op_reg == OP_CLEAR) ? AFTER_CLEAR : AFTER_SETTLE;
            end
        end
    end

    // digit unit requests: hours at accept, then minutes and seconds
    always_comb
    begin
        dreq.start = 1'b0;
        dreq.value = req.hours;
        if (accept && (req.op == OP_TIME))
        begin
            dreq.start = 1'b1;
        end
        else if ((state_reg == ST_DIV) && drsp.done && (fld_reg != 2'd2))
        begin
            dreq.start = 1'b1;
            dreq.value = (fld_reg == 2'd0) ? min_reg : sec_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        fld_next   = fld_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = 4'd0;
                fld_next  = 2'd0;
                if (accept)
                begin
                    if (req.op == OP_TIME)
                    begin
                        state_next = ST_DIV;
                    end
                    else if (req.op < OP_TIME)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_DIV:
            begin
                if (drsp.done)
                begin
                    if (fld_reg == 2'd2)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        fld_next = fld_reg + 2'd1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (gen_ready)
                begin
                    if (gen_item.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + 4'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 4'd0;
            fld_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            fld_reg   <= fld_next;
        end
    end

    // request payload and finished digits
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.op;
            byte_reg <= req.byte_value;
            row_reg  <= req.row;
            col_reg  <= req.col;
            min_reg  <= req.minutes;
            sec_reg  <= req.seconds;
        end
        if ((state_reg == ST_DIV) && drsp.done)
        begin
            tens_reg[fld_reg] <= drsp.tens;
            ones_reg[fld_reg] <= drsp.ones;
        end
    end

endmodule

`default_nettype wire

[rtl/char_lcd_nibble_sequencer_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Character-LCD 4-bit strobe sequencer. Each request on req turns into a run of
// strobes on strobe, one per cycle while the sink is ready: 13 for initialisation,
// 2 for command, data, goto and clear, 16 for a time string, none for codes 6 and 7.
// A time request first splits hours, minutes and seconds into decimal digits on a
// single subtract-ten unit, one value after another, the next value loading in the
// cycle the previous one finishes. An unused code is accepted and starts no run.
// req is not ready until the last strobe of the request has entered the output
// register, which then lets the next request in while that strobe waits.

`include "char_lcd_nibble_sequencer_core_macros.svh"

module char_lcd_nibble_sequencer_core
    import clns_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    clns_req_if.sink     req,
    clns_strobe_if.source strobe
);

    clns_div_req_t dreq;
    clns_div_rsp_t drsp;
    logic          gen_valid;
    logic          gen_ready;
    clns_strobe_t  gen_item;

    logic          out_valid_reg, out_valid_next;
    clns_strobe_t  out_item_reg;

    // digit unit
    clns_div10 u_div10 (
        .clk  (clk),
        .rst_n(rst_n),
        .dreq (dreq),
        .drsp (drsp)
    );

    // request sequencer
    clns_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .dreq     (dreq),
        .drsp     (drsp),
        .gen_valid(gen_valid),
        .gen_ready(gen_ready),
        .gen_item (gen_item)
    );

    // output register
    assign gen_ready = !out_valid_reg || strobe.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (gen_valid && gen_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (strobe.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen_valid && gen_ready)
        begin
            out_item_reg <= gen_item;
        end
    end

    assign strobe.valid       = out_valid_reg;
    assign strobe.reg_select  = out_item_reg.reg_select;
    assign strobe.nibble      = out_item_reg.nibble;
    assign strobe.wait_before = out_item_reg.wait_before;
    assign strobe.wait_after  = out_item_reg.wait_after;
    assign strobe.last        = out_item_reg.last;

    // checks
    `CLNS_ASSERT_SAME(a_after_only_last, clk, rst_n, strobe.valid && !strobe.last, strobe.wait_after == AFTER_NONE, "settle delay on a strobe that is not the last")
    `CLNS_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req.valid && req.ready && (req.op <= OP_TIME), !req.ready, "sequencer ready again straight after a request")
    `CLNS_ASSERT_NEXT(a_unused_op_idle, clk, rst_n, req.valid && req.ready && (req.op > OP_TIME), req.ready && !gen_valid, "unused request code started a run")

endmodule

`default_nettype wire
